// ===== design/srp_pkg.sv =====
// Package for the streaming pattern replace block: parameters, register codes,
// payload structs and the command passed between the front and back ends.
// No dependencies.
`timescale 1ns / 1ps

package srp_pkg;

  localparam int MAX_PATTERN_BYTES     = 8;
  localparam int MAX_REPLACEMENT_BYTES = 8;
  localparam int CMD_FIFO_DEPTH        = 4;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } srp_reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } srp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } srp_out_t;

  typedef struct packed {
    logic                  we;
    srp_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } srp_cfg_wr_t;

  // A run of up to eight bytes to emit, first byte in bits 7..0. A zero count
  // with last set stands for a bare end marker.
  typedef struct packed {
    logic [63:0]      data;
    logic [LEN_W-1:0] cnt;
    logic             last;
  } srp_cmd_t;

endpackage

// ===== design/srp_front.sv =====
// Front end: configuration registers, the match window and classification of
// each accepted byte into an output command. Depends on srp_pkg.
`timescale 1ns / 1ps

module srp_front #(
  parameter int MaxPatternBytes     = srp_pkg::MAX_PATTERN_BYTES,
  parameter int MaxReplacementBytes = srp_pkg::MAX_REPLACEMENT_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srp_pkg::srp_cfg_wr_t cfg_i,
  input  logic                push_i,
  input  srp_pkg::srp_in_t    in_i,
  input  logic                q_full_i,
  output logic                cmd_push_o,
  output srp_pkg::srp_cmd_t   cmd_o
);

  localparam int LenW = srp_pkg::LEN_W;
  localparam int CntW = $clog2(MaxPatternBytes + 1);

  logic [63:0]     pattern_q, replacement_q;
  logic [LenW-1:0] pat_len_q, rep_len_q;
  logic [7:0]      win_q [MaxPatternBytes];
  logic [7:0]      win_d [MaxPatternBytes];
  logic [7:0]      nw    [MaxPatternBytes];
  logic [CntW-1:0] count_q, count_d;
  logic [LenW-1:0] plen, rlen, ncnt;
  logic            accept, hit, eq, match;

  function automatic logic [LenW-1:0] eff_plen(input logic [LenW-1:0] v);
    logic [LenW-1:0] r;
    r = v;
    if (v == '0) r = LenW'(1);
    else if (v > LenW'(MaxPatternBytes)) r = LenW'(MaxPatternBytes);
    return r;
  endfunction

  assign plen   = eff_plen(pat_len_q);
  assign rlen   = (rep_len_q > LenW'(MaxReplacementBytes)) ?
                  LenW'(MaxReplacementBytes) : rep_len_q;
  assign accept = push_i && !q_full_i;
  assign ncnt   = LenW'(count_q) + LenW'(1);
  assign hit    = (ncnt == plen);
  assign match  = hit && eq;

  always_comb begin
    eq = 1'b1;
    for (int i = 0; i < MaxPatternBytes; i++) begin
      nw[i] = (CntW'(i) == count_q) ? in_i.in_byte : win_q[i];
      if (LenW'(i) < plen && nw[i] != pattern_q[8*i +: 8]) eq = 1'b0;
    end
  end

  always_comb begin
    win_d      = win_q;
    count_d    = count_q;
    cmd_o      = '0;
    cmd_push_o = 1'b0;
    if (accept) begin
      priority if (match) begin
        count_d    = '0;
        cmd_o.data = replacement_q;
        cmd_o.cnt  = rlen;
        cmd_o.last = in_i.in_last;
        cmd_push_o = (rlen != '0) || in_i.in_last;
      end else if (in_i.in_last) begin
        count_d = '0;
        for (int i = 0; i < MaxPatternBytes; i++) begin
          cmd_o.data[8*i +: 8] = nw[i];
        end
        cmd_o.cnt  = ncnt;
        cmd_o.last = 1'b1;
        cmd_push_o = 1'b1;
      end else if (hit) begin
        // The oldest byte can no longer start a match: send it and slide.
        cmd_o.data[7:0] = nw[0];
        cmd_o.cnt       = LenW'(1);
        cmd_push_o      = 1'b1;
        for (int i = 0; i < MaxPatternBytes - 1; i++) begin
          win_d[i] = nw[i+1];
        end
      end else begin
        win_d   = nw;
        count_d = CntW'(ncnt);
      end
    end
    // A shorter pattern length drops a window that no longer fits.
    if (cfg_i.we && cfg_i.idx == srp_pkg::REG_PATTERN_LENGTH &&
        LenW'(count_q) >= eff_plen(cfg_i.data[LenW-1:0])) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q     <= '0;
      pat_len_q     <= LenW'(1);
      replacement_q <= '0;
      rep_len_q     <= '0;
      count_q       <= '0;
    end else begin
      count_q <= count_d;
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          srp_pkg::REG_PATTERN_BYTES:      pattern_q     <= cfg_i.data;
          srp_pkg::REG_PATTERN_LENGTH:     pat_len_q     <= cfg_i.data[LenW-1:0];
          srp_pkg::REG_REPLACEMENT_BYTES:  replacement_q <= cfg_i.data;
          srp_pkg::REG_REPLACEMENT_LENGTH: rep_len_q     <= cfg_i.data[LenW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== design/srp_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on srp_pkg.
`timescale 1ns / 1ps

module srp_cmd_fifo #(
  parameter int Depth = srp_pkg::CMD_FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  srp_pkg::srp_cmd_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output srp_pkg::srp_cmd_t rd_data_o,
  output logic              not_empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  srp_pkg::srp_cmd_t mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o      = (cnt_q == CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign do_wr       = wr_i && !full_o;
  assign do_rd       = rd_i && not_empty_o;
  assign rd_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= inc(wptr_q);
      if (do_rd) rptr_q <= inc(rptr_q);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CntW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

// ===== design/srp_back.sv =====
// Back end: expands queued commands into result items, one per cycle when the
// output register that holds the oldest result is free. Depends on srp_pkg.
`timescale 1ns / 1ps

module srp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_avail_i,
  input  srp_pkg::srp_cmd_t cmd_i,
  output logic              cmd_take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output srp_pkg::srp_out_t out_o
);

  localparam int LenW = srp_pkg::LEN_W;

  logic [63:0]       data_q;
  logic [LenW-1:0]   rem_q;
  logic              vbit_q, last_q;
  logic              out_full_q;
  srp_pkg::srp_out_t out_q, item;
  logic              busy, out_free, emit, done;

  assign busy       = (rem_q != '0);
  assign out_free   = !out_full_q || pop_i;
  assign emit       = busy && out_free;
  assign done       = !busy || (emit && rem_q == LenW'(1));
  assign cmd_take_o = done && cmd_avail_i;

  assign item.out_byte  = vbit_q ? data_q[7:0] : 8'd0;
  assign item.out_valid = vbit_q;
  assign item.out_last  = last_q && (rem_q == LenW'(1));

  assign empty_o = !out_full_q;
  assign out_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (cmd_take_o) begin
        // A bare end marker becomes a single item with no valid byte.
        rem_q <= (cmd_i.cnt == '0) ? LenW'(1) : cmd_i.cnt;
      end else if (emit) begin
        rem_q <= rem_q - LenW'(1);
      end
      if (emit) out_full_q <= 1'b1;
      else if (pop_i) out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      data_q <= cmd_i.data;
      vbit_q <= (cmd_i.cnt != '0);
      last_q <= cmd_i.last;
    end else if (emit) begin
      data_q <= {8'd0, data_q[63:8]};
    end
    if (emit) out_q <= item;
  end

endmodule

// ===== design/stream_pattern_replace_core.sv =====
// Top level of the streaming pattern replace block.
// Depends on srp_pkg, srp_front, srp_cmd_fifo and srp_back.
`timescale 1ns / 1ps

// Usage:
// Bytes enter on in_i with push; a transfer happens when push is high and
// full is low. Results leave on out_o: the oldest result is shown while empty
// is low and a transfer happens when pop is high.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) and is
// to be written only while the stream is idle; the block does not enforce this.
// Pattern and replacement bytes are given first byte in bits 7..0.
// Each input transfer is classified combinationally by the front end and yields
// at most one command of 0 to 8 output bytes, queued in a four-entry command
// queue. The back end takes a command once the previous one is done and emits
// one result per cycle while the output register is free or popped, so a byte
// that leaves the window passes the queue and back end into the output register.
// Sustained input rate is one byte per cycle while results average at most
// one per input and the receiver keeps up; replacement or flush bursts are
// absorbed by the queue, and full rises when it holds four commands.
// When the receiver stalls, the output register holds its result, the queue
// fills and then full stops input. Reset empties the window, the queue and the
// output register and clears the configuration registers except the pattern
// length, which becomes one.

module stream_pattern_replace_core #(
  parameter int MaxPatternBytes     = srp_pkg::MAX_PATTERN_BYTES,
  parameter int MaxReplacementBytes = srp_pkg::MAX_REPLACEMENT_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  srp_pkg::srp_in_t                in_i,
  output logic                            empty,
  input  logic                            pop,
  output srp_pkg::srp_out_t               out_o
);

  srp_pkg::srp_cfg_wr_t cfg;
  srp_pkg::srp_cmd_t    cmd_wr, cmd_rd;
  logic                 cmd_push, cmd_avail, cmd_take;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = srp_pkg::srp_reg_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  srp_front #(
    .MaxPatternBytes    (MaxPatternBytes),
    .MaxReplacementBytes(MaxReplacementBytes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .push_i    (push),
    .in_i      (in_i),
    .q_full_i  (full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_wr)
  );

  srp_cmd_fifo #(
    .Depth(srp_pkg::CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (cmd_push),
    .wr_data_i  (cmd_wr),
    .full_o     (full),
    .rd_i       (cmd_take),
    .rd_data_o  (cmd_rd),
    .not_empty_o(cmd_avail)
  );

  srp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_avail_i(cmd_avail),
    .cmd_i      (cmd_rd),
    .cmd_take_o (cmd_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_o)
  );

endmodule

// ===== design/srp_checker.sv =====
// Port-level checks for the streaming pattern replace block, bound to the
// top level. Depends on srp_pkg and stream_pattern_replace_core.
`timescale 1ns / 1ps

module srp_props (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input srp_pkg::srp_out_t out_o
);

  // No result is shown once reset has been applied at a clock edge.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown after reset");

  // A bare end marker only ever closes a stream.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.out_valid) |-> out_o.out_last)
    else $error("marker item without last");

  // A marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.out_valid) |-> (out_o.out_byte == 8'd0))
    else $error("marker item with nonzero byte");

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("stalled result changed");

endmodule

bind stream_pattern_replace_core srp_props u_srp_checker (.*);

// ===== verif/srp_checker.sv =====
// Scoreboard for stream_pattern_replace_core: watches the configuration port and
// both queue-style channels, predicts the replaced byte stream and compares results.
// Depends on srp_pkg.
`timescale 1ns / 1ps

module srp_checker
  import srp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push_i,
  input  logic                  full_i,
  input  srp_in_t               in_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  srp_out_t              out_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o,
  output int unsigned           results_o,
  output int unsigned           hits_o
);

  localparam int unsigned REPORT_LIMIT = 20;

  logic [63:0] pat_bytes;
  logic [63:0] rep_bytes;
  logic [3:0]  pat_len_raw;
  logic [3:0]  rep_len_raw;
  logic [7:0]  win [MAX_PATTERN_BYTES];
  int unsigned win_cnt;
  srp_out_t    expected_q[$];
  int unsigned errors = 0;
  int unsigned results = 0;
  int unsigned hits = 0;

  assign errors_o  = errors;
  assign results_o = results;
  assign hits_o    = hits;

  function automatic int unsigned pat_len();
    if (pat_len_raw == 4'd0) return 1;
    if (pat_len_raw > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return int'(pat_len_raw);
  endfunction

  function automatic void expect_byte(input logic [7:0] value, input logic valid);
    srp_out_t item;
    item.out_byte  = value;
    item.out_valid = valid;
    item.out_last  = 1'b0;
    expected_q.push_back(item);
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%0t srp_checker: %s", $time, what);
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PATTERN_BYTES: pat_bytes = data;
      REG_PATTERN_LENGTH: begin
        // A shorter pattern drops a window that already reaches its length.
        pat_len_raw = data[LEN_W-1:0];
        if (win_cnt >= pat_len()) win_cnt = 0;
      end
      REG_REPLACEMENT_BYTES: rep_bytes = data;
      default: rep_len_raw = data[LEN_W-1:0];
    endcase
  endtask

  task automatic predict(input srp_in_t item);
    int unsigned plen;
    int unsigned rlen;
    int unsigned n;
    bit          hit;
    srp_out_t    tail;
    plen = pat_len();
    rlen = (rep_len_raw > MAX_REPLACEMENT_BYTES) ? MAX_REPLACEMENT_BYTES : int'(rep_len_raw);
    n = 0;
    if (win_cnt >= plen) win_cnt = 0;
    win[win_cnt] = item.in_byte;
    win_cnt++;
    if (win_cnt == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        hits++;
        for (int i = 0; i < rlen; i++) expect_byte(rep_bytes[8*i +: 8], 1'b1);
        n += rlen;
        win_cnt = 0;
      end else if (!item.in_last) begin
        // The oldest byte can no longer start a match, so it leaves the window.
        expect_byte(win[0], 1'b1);
        n++;
        for (int i = 0; i + 1 < win_cnt; i++) win[i] = win[i+1];
        win_cnt--;
      end
    end
    if (item.in_last) begin
      for (int i = 0; i < win_cnt; i++) expect_byte(win[i], 1'b1);
      n += win_cnt;
      win_cnt = 0;
      if (n == 0) expect_byte(8'h00, 1'b0);
      tail = expected_q.pop_back();
      tail.out_last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  task automatic check(input srp_out_t got);
    srp_out_t want;
    results++;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result byte %h valid %b last %b",
                       got.out_byte, got.out_valid, got.out_last));
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("result %0d: out_byte %h, expected %h", results, got.out_byte,
                       want.out_byte));
    if (got.out_valid !== want.out_valid)
      report($sformatf("result %0d: out_valid %b, expected %b", results, got.out_valid,
                       want.out_valid));
    if (got.out_last !== want.out_last)
      report($sformatf("result %0d: out_last %b, expected %b", results, got.out_last,
                       want.out_last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes   = '0;
      pat_len_raw = 4'd1;
      rep_bytes   = '0;
      rep_len_raw = '0;
      win_cnt     = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (push_i && !full_i) predict(in_i);
      if (pop_i && !empty_i) check(out_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the stream_pattern_replace_core testbench: clock, reset, configuration,
// byte stimulus with bursts and gaps, a stalling receiver, and the verdict.
// Depends on srp_pkg, stream_pattern_replace_core and srp_checker.
`timescale 1ns / 1ps

module testbench;
  import srp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 280;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push     = 1'b0;
  logic                  full;
  srp_in_t               in_item  = '0;
  logic                  empty;
  logic                  pop      = 1'b0;
  srp_out_t              out_item;

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned hits;
  int unsigned bytes_sent   = 0;
  int unsigned streams_sent = 0;
  int unsigned burst_left   = 0;
  int unsigned cycles       = 0;
  int unsigned stall_mode   = 0;
  int unsigned random_goal;
  logic [63:0] cur_pattern  = '0;
  int unsigned cur_plen     = 1;

  stream_pattern_replace_core uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .push      (push),
    .full      (full),
    .in_i      (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_o     (out_item)
  );

  srp_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .push_i    (push),
    .full_i    (full),
    .in_i      (in_item),
    .empty_i   (empty),
    .pop_i     (pop),
    .out_i     (out_item),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results),
    .hits_o    (hits)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: timed out after %0d cycles with %0d results outstanding",
               cycles, pending);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // The receiver switches between free-running, light, heavy and near-total stalls.
  always @(posedge clk_i) begin
    if ((cycles % 97) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 7) != 0);
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(input srp_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    int unsigned raw;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_PATTERN_BYTES) cur_pattern = value;
    if (idx == REG_PATTERN_LENGTH) begin
      raw = value[LEN_W-1:0];
      cur_plen = (raw == 0) ? 1 : (raw > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : raw;
    end
  endtask

  // Holds input back until every predicted result has been transferred out.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    srp_in_t     item;
    item.in_byte = value;
    item.in_last = last;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push    <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
    if (last) streams_sent++;
  endtask

  // Content is mostly pattern copies, broken copies and pattern bytes, with some noise.
  task automatic send_stream(input int unsigned len);
    logic [7:0]  content[$];
    logic [7:0]  b;
    int unsigned sel;
    int unsigned cut;
    while (content.size() < len) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        for (int i = 0; i < cur_plen; i++) content.push_back(cur_pattern[8*i +: 8]);
      end else if (sel < 5) begin
        cut = $urandom_range(1, cur_plen);
        for (int i = 0; i < cut; i++) begin
          b = cur_pattern[8*i +: 8];
          if (i + 1 == cut) b = b ^ 8'($urandom_range(1, 255));
          content.push_back(b);
        end
      end else if (sel < 8) begin
        cut = $urandom_range(0, cur_plen - 1);
        content.push_back(cur_pattern[8*cut +: 8]);
      end else begin
        content.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (content[k]) begin
      if (k > 0 && $urandom_range(0, 39) == 0) begin
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, {$urandom, $urandom});
      end
      send_byte(content[k], k + 1 == content.size());
    end
  endtask

  task automatic random_config();
    logic [63:0] pat;
    logic [63:0] rep;
    int unsigned plen;
    int unsigned rlen;
    case ($urandom_range(0, 5))
      0: pat = '0;
      1: pat = '1;
      2: begin
        // A two-letter alphabet gives self-overlapping patterns.
        for (int i = 0; i < 8; i++) pat[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
      end
      default: pat = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 3))
      0:       rep = '0;
      1:       rep = '1;
      default: rep = {$urandom, $urandom};
    endcase
    plen = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
    rlen = $urandom_range(0, 15);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, {$urandom, 28'($urandom), 4'(plen)});
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, {32'd0, 28'($urandom_range(0, 1)), 4'(rlen)});
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one-byte pattern 00 and an empty replacement.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);

    // Two-byte pattern with junk in the unused bytes and junk above the length field.
    wait_idle();
    write_reg(REG_PATTERN_BYTES, 64'hA5C3_0F96_E1B4_6261);
    write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF2);
    write_reg(REG_REPLACEMENT_BYTES, 64'h1234_5678_9A5A_5958);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd3);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);

    // Oversized lengths saturate to eight bytes.
    wait_idle();
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7);

    // A shorter pattern length written while the window holds three bytes drops them.
    wait_idle();
    write_reg(REG_PATTERN_BYTES, 64'h0807_0605_0403_0201);
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    write_reg(REG_REPLACEMENT_BYTES, '0);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
    for (int i = 0; i < 3; i++) send_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);

    // Length zero acts as one; a deleted final byte leaves only the end marker.
    wait_idle();
    write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    send_byte(8'h01, 1'b1);

    random_goal = bytes_sent + RANDOM_ITEMS;
    wait_idle();
    random_config();
    while (bytes_sent < random_goal) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        random_config();
      end
      send_stream(($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12));
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("testbench: %0d content bytes in %0d streams, %0d results compared, %0d pattern hits",
             bytes_sent, streams_sent, results, hits);
    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: %0d mismatches", errors);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/srp_pkg.sv
design/srp_front.sv
design/srp_cmd_fifo.sv
design/srp_back.sv
design/stream_pattern_replace_core.sv
design/srp_checker.sv
verif/srp_checker.sv
verif/testbench.sv
